/* sv/lsb_first_bit_reader_assert.svh */
// ----------------------------------------------------------------------------
// LSB-first bit reader assertion macros
// Concurrent assertion wrappers, sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LSB_FIRST_BIT_READER_ASSERT_SVH
`define LSB_FIRST_BIT_READER_ASSERT_SVH
`ifndef SYNTHESIS
`define LSBR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define LSBR_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define LSBR_ASSERT_ALWAYS(label, cond, msg)
`define LSBR_ASSERT_IMPLY(label, ante, cons, msg)
`endif
`endif

/* sv/lsbr_pkg.sv */
// ----------------------------------------------------------------------------
// LSB-first bit reader package
// Field widths, item modes and result status codes of the bit reader.
// ----------------------------------------------------------------------------
package lsbr_pkg;

  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned BYTE_SHIFT    = 3;
  localparam int unsigned MAX_READ_BITS = 32;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned NBYTES_W = 3;
  localparam int unsigned NBITS_W  = 6;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned HELD_W   = 7;

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam mode_t MODE_PUSH  = 2'd0;
  localparam mode_t MODE_READ  = 2'd1;
  localparam mode_t MODE_LIMIT = 2'd2;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_FEW     = 2'd1;
  localparam status_t ST_LIMIT   = 2'd2;
  localparam status_t ST_REFUSED = 2'd3;

endpackage

/* sv/lsb_first_bit_reader.sv */
// ----------------------------------------------------------------------------
// LSB-first variable-length bit reader
// Pipeline: input register, combinational shifter and counters, then result register.
// Throughput: one transaction per cycle while out_stall does not hold the result.
// Reset: synchronous, active low; clears the accumulator, the held count and
// both valid flags, and sets the bit limit to all ones.
// ----------------------------------------------------------------------------
`include "lsb_first_bit_reader_assert.svh"

module lsb_first_bit_reader #(
  parameter int unsigned WORD_BITS = lsbr_pkg::WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lsbr_pkg::MODE_W-1:0]   in_mode,
  input  logic [lsbr_pkg::DATA_W-1:0]   in_word,
  input  logic [lsbr_pkg::NBYTES_W-1:0] in_valid_bytes,
  input  logic [lsbr_pkg::NBITS_W-1:0]  in_bit_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lsbr_pkg::DATA_W-1:0]   out_value,
  output logic [lsbr_pkg::STATUS_W-1:0] out_status,
  output logic [lsbr_pkg::HELD_W-1:0]   out_bits_held
);
  import lsbr_pkg::*;

  // The accumulator only ever holds fewer than WORD_BITS bits before a push,
  // and a push adds at most WORD_BITS, so twice the word width is enough.
  localparam int unsigned ACC_W     = 2 * WORD_BITS;
  localparam int unsigned MAX_BYTES = WORD_BITS / BITS_PER_BYTE;

  // Input register stage.
  logic                s1_valid_r;
  mode_t               s1_mode_r;
  logic [DATA_W-1:0]   s1_word_r;
  logic [NBYTES_W-1:0] s1_nbytes_r;
  logic [NBITS_W-1:0]  s1_nbits_r;

  // Reader state.
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [HELD_W-1:0] held_r, held_nxt;
  logic [DATA_W-1:0] allowed_r, allowed_nxt;

  // Result register stage.
  logic              out_valid_r;
  logic [DATA_W-1:0] out_value_r;
  status_t           out_status_r;
  logic [HELD_W-1:0] out_held_r;

  logic              adv;
  logic              s1_fire;
  logic [DATA_W-1:0] value_nxt;
  status_t           status_nxt;

  // Push path signals.
  logic [NBYTES_W-1:0]  nbytes_sat;
  logic [HELD_W-1:0]    add_bits;
  logic [WORD_BITS-1:0] word_lo;
  logic [ACC_W-1:0]     push_acc;

  // Read path signals.
  logic [NBITS_W-1:0] nbits_sat;
  logic               too_few;
  logic               over_limit;
  logic [DATA_W-1:0]  read_value;

  // The result register moves on when it is empty or its transaction is taken.
  // The input register then hands its item over, so a new input transaction
  // is taken in the same cycle and the pipe runs at one item per cycle.
  assign adv      = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;

  // Push: the byte count saturates at the bytes of one word. Stale bits above
  // the held bits are masked off before the new bytes are laid over them.
  assign nbytes_sat = (s1_nbytes_r > NBYTES_W'(MAX_BYTES)) ? NBYTES_W'(MAX_BYTES)
                                                           : s1_nbytes_r;
  assign add_bits   = HELD_W'(nbytes_sat) << BYTE_SHIFT;
  assign word_lo    = s1_word_r[WORD_BITS-1:0] & ~({WORD_BITS{1'b1}} << add_bits);
  assign push_acc   = (acc_r & ~({ACC_W{1'b1}} << held_r))
                    | (ACC_W'(word_lo) << held_r);

  // Read: the request saturates at thirty-two bits. A shift by the full
  // width leaves zero, so the mask is all ones for a thirty-two bit read.
  assign nbits_sat  = (s1_nbits_r > NBITS_W'(MAX_READ_BITS)) ? NBITS_W'(MAX_READ_BITS)
                                                             : s1_nbits_r;
  assign too_few    = held_r < HELD_W'(nbits_sat);
  assign over_limit = allowed_r < DATA_W'(nbits_sat);
  assign read_value = DATA_W'(acc_r) & ~({DATA_W{1'b1}} << nbits_sat);

  always_comb begin
    acc_nxt     = acc_r;
    held_nxt    = held_r;
    allowed_nxt = allowed_r;
    value_nxt   = '0;
    status_nxt  = ST_OK;
    case (s1_mode_r)
      MODE_PUSH: begin
        if (held_r >= HELD_W'(WORD_BITS)) begin
          status_nxt = ST_REFUSED;
        end else begin
          acc_nxt  = push_acc;
          held_nxt = held_r + add_bits;
        end
      end
      MODE_READ: begin
        if (too_few) begin
          status_nxt = ST_FEW;
        end else if (over_limit) begin
          status_nxt = ST_LIMIT;
        end else begin
          value_nxt   = read_value;
          acc_nxt     = acc_r >> nbits_sat;
          held_nxt    = held_r - HELD_W'(nbits_sat);
          allowed_nxt = allowed_r - DATA_W'(nbits_sat);
        end
      end
      MODE_LIMIT: begin
        allowed_nxt = s1_word_r;
      end
      default: begin
        // The unused mode leaves the state alone and reports success.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      held_r      <= '0;
      allowed_r   <= '1;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_fire) begin
        acc_r     <= acc_nxt;
        held_r    <= held_nxt;
        allowed_r <= allowed_nxt;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_mode_r   <= in_mode;
      s1_word_r   <= in_word;
      s1_nbytes_r <= in_valid_bytes;
      s1_nbits_r  <= in_bit_count;
    end
    if (s1_fire) begin
      out_value_r  <= value_nxt;
      out_status_r <= status_nxt;
      out_held_r   <= held_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_status    = out_status_r;
  assign out_bits_held = out_held_r;

  // The held count never reaches the accumulator width.
  `LSBR_ASSERT_ALWAYS(a_held_range, held_r < HELD_W'(ACC_W), "held count overflow")
  // A failed transaction never carries stream bits.
  `LSBR_ASSERT_IMPLY(a_fail_zero, out_valid_r && out_status_r != ST_OK, out_value_r == '0, "value not zero on failure")
  // A refused push only happens with a full word or more held.
  `LSBR_ASSERT_IMPLY(a_refuse_full, out_valid_r && out_status_r == ST_REFUSED, out_held_r >= HELD_W'(WORD_BITS), "push refused below one word")

endmodule
